[rtl/cdr_pkg.sv]
package cdr_pkg;

   localparam int HDR_LEN    = 12;
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

   // Configuration register indexes.
   localparam logic [1:0] CSR_RESOLVED_IP = 2'd0;
   localparam logic [1:0] CSR_ANSWER_TTL  = 2'd1;
   localparam logic [1:0] CSR_ERROR_RCODE = 2'd2;

   localparam logic [31:0] RESOLVED_IP_RESET = 32'd0;
   localparam logic [31:0] ANSWER_TTL_RESET  = 32'd60;
   localparam logic [3:0]  ERROR_RCODE_RESET = 4'd3;

   typedef logic [HDR_LEN-1:0][7:0] hdr_type;

   typedef enum logic [1:0] {
      CMD_BYTE,
      CMD_HDR_ANS,
      CMD_HDR_ERR
   } cmd_kind_type;

   // One request for the back end: a passed byte or a header reply, and
   // whether the answer record follows it.
   typedef struct packed {
      cmd_kind_type kind;
      logic         with_record;
      logic [7:0]   data;
   } q_entry_type;

endpackage

[rtl/cdr_front.sv]
module cdr_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [7:0]          req_tdata,
   input  logic                req_tlast,
   output logic                push_valid,
   output cdr_pkg::q_entry_type push_entry,
   input  logic                fifo_full,
   input  logic                hdr_taken,
   output cdr_pkg::hdr_type    header
);
   import cdr_pkg::*;

   typedef enum logic [1:0] {
      MODE_COLLECT,
      MODE_PASS,
      MODE_DISCARD
   } mode_type;

   localparam logic [3:0] LAST_HDR_IDX = 4'(HDR_LEN - 1);

   mode_type    mode_ff, mode_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic        pending_ff, pending_in;
   hdr_type     store_ff, store_in;
   logic        accept;
   logic        is_query, op_zero, one_q;

   // The header store must not be overwritten while the back end has yet
   // to copy out a queued header reply.
   assign req_tready = !fifo_full && !(mode_ff == MODE_COLLECT && pending_ff);
   assign accept     = req_tvalid && req_tready;
   assign header     = store_ff;

   assign is_query = !store_ff[2][7];
   assign op_zero  = store_ff[2][6:3] == 4'd0;
   assign one_q    = store_ff[4] == 8'd0 && store_ff[5] == 8'd1 &&
                     store_ff[6] == 8'd0 && store_ff[7] == 8'd0 &&
                     store_ff[8] == 8'd0 && store_ff[9] == 8'd0;

   always_comb begin
      mode_in    = mode_ff;
      cnt_in     = cnt_ff;
      pending_in = pending_ff && !hdr_taken;
      store_in   = store_ff;
      push_valid = 1'b0;
      push_entry = '{kind: CMD_BYTE, with_record: req_tlast, data: req_tdata};
      if (accept) begin
         unique case (mode_ff)
            MODE_COLLECT: begin
               store_in[cnt_ff] = req_tdata;
               if (cnt_ff != LAST_HDR_IDX) begin
                  cnt_in = req_tlast ? 4'd0 : cnt_ff + 4'd1;
               end else begin
                  cnt_in = 4'd0;
                  if (!is_query) begin
                     mode_in = req_tlast ? MODE_COLLECT : MODE_DISCARD;
                  end else if (op_zero && one_q) begin
                     push_valid      = 1'b1;
                     push_entry.kind = CMD_HDR_ANS;
                     pending_in      = 1'b1;
                     mode_in         = req_tlast ? MODE_COLLECT : MODE_PASS;
                  end else begin
                     push_valid      = 1'b1;
                     push_entry.kind = CMD_HDR_ERR;
                     pending_in      = 1'b1;
                     mode_in         = req_tlast ? MODE_COLLECT : MODE_DISCARD;
                  end
               end
            end
            MODE_PASS: begin
               push_valid = 1'b1;
               if (req_tlast) begin
                  mode_in = MODE_COLLECT;
               end
            end
            default: begin
               if (req_tlast) begin
                  mode_in = MODE_COLLECT;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_COLLECT;
         cnt_ff     <= 4'd0;
         pending_ff <= 1'b0;
      end else begin
         mode_ff    <= mode_in;
         cnt_ff     <= cnt_in;
         pending_ff <= pending_in;
      end
      store_ff <= store_in;
   end

endmodule

[rtl/cdr_fifo.sv]
module cdr_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  cdr_pkg::q_entry_type push_entry,
   output logic                 full,
   input  logic                 pop,
   output cdr_pkg::q_entry_type pop_entry,
   output logic                 empty
);
   import cdr_pkg::*;

   q_entry_type              slot_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0]       wr_ff, wr_in, rd_ff, rd_in;
   logic [FIFO_AW:0]         count_ff, count_in;

   assign full      = count_ff == (FIFO_AW + 1)'(FIFO_DEPTH);
   assign empty     = count_ff == '0;
   assign pop_entry = slot_ff[rd_ff];

   always_comb begin
      wr_in    = push ? wr_ff + FIFO_AW'(1) : wr_ff;
      rd_in    = pop ? rd_ff + FIFO_AW'(1) : rd_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + (FIFO_AW + 1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (FIFO_AW + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
      if (push) begin
         slot_ff[wr_ff] <= push_entry;
      end
   end

endmodule

[rtl/cdr_back.sv]
module cdr_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fifo_empty,
   input  cdr_pkg::q_entry_type fifo_entry,
   output logic                 fifo_pop,
   input  cdr_pkg::hdr_type     header,
   output logic                 hdr_taken,
   input  logic [31:0]          resolved_ip,
   input  logic [31:0]          answer_ttl,
   input  logic [3:0]           error_rcode,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [7:0]           rsp_tdata,
   output logic                 rsp_tlast,
   output logic [0:0]           rsp_tuser
);
   import cdr_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_HDR,
      ST_REC
   } state_type;

   localparam logic [3:0] LAST_HDR_IDX = 4'(HDR_LEN - 1);

   state_type   state_ff, state_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic        rec_ff, rec_in;
   logic        err_ff, err_in;
   hdr_type     hdr_ff, hdr_in;
   logic        valid_ff, valid_in;
   logic [7:0]  data_ff, data_in;
   logic        last_ff, last_in;
   logic        kind_ff, kind_in;
   logic        load_ok;

   // Fixed part of the answer record: name pointer, type A, class IN,
   // then the TTL, the data length and the address.
   function automatic logic [7:0] rec_byte(input logic [3:0] idx,
                                           input logic [31:0] ttl,
                                           input logic [31:0] ip);
      logic [7:0] b;
      unique case (idx)
         4'd0:    b = 8'hC0;
         4'd1:    b = 8'h0C;
         4'd2:    b = 8'h00;
         4'd3:    b = 8'h01;
         4'd4:    b = 8'h00;
         4'd5:    b = 8'h01;
         4'd6:    b = ttl[31:24];
         4'd7:    b = ttl[23:16];
         4'd8:    b = ttl[15:8];
         4'd9:    b = ttl[7:0];
         4'd10:   b = 8'h00;
         4'd11:   b = 8'h04;
         4'd12:   b = ip[31:24];
         4'd13:   b = ip[23:16];
         4'd14:   b = ip[15:8];
         default: b = ip[7:0];
      endcase
      return b;
   endfunction

   assign load_ok    = !valid_ff || rsp_tready;
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = kind_ff;

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      rec_in    = rec_ff;
      err_in    = err_ff;
      hdr_in    = hdr_ff;
      valid_in  = valid_ff && !rsp_tready;
      data_in   = data_ff;
      last_in   = last_ff;
      kind_in   = kind_ff;
      fifo_pop  = 1'b0;
      hdr_taken = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (load_ok && !fifo_empty) begin
               fifo_pop = 1'b1;
               rec_in   = fifo_entry.with_record;
               cnt_in   = 4'd0;
               unique case (fifo_entry.kind)
                  CMD_HDR_ANS: begin
                     hdr_taken   = 1'b1;
                     hdr_in      = header;
                     hdr_in[2]   = header[2] | 8'h80;
                     hdr_in[6]   = header[4];
                     hdr_in[7]   = header[5];
                     err_in      = 1'b0;
                     state_in    = ST_HDR;
                  end
                  CMD_HDR_ERR: begin
                     hdr_taken   = 1'b1;
                     hdr_in      = header;
                     hdr_in[2]   = header[2] | 8'h80;
                     hdr_in[3]   = {header[3][7:4], error_rcode};
                     hdr_in[4]   = 8'h00;
                     hdr_in[5]   = 8'h00;
                     err_in      = 1'b1;
                     state_in    = ST_HDR;
                  end
                  default: begin
                     valid_in = 1'b1;
                     data_in  = fifo_entry.data;
                     last_in  = 1'b0;
                     kind_in  = 1'b0;
                     if (fifo_entry.with_record) begin
                        state_in = ST_REC;
                     end
                  end
               endcase
            end
         end
         ST_HDR: begin
            if (load_ok) begin
               valid_in = 1'b1;
               data_in  = hdr_ff[0];
               kind_in  = err_ff;
               last_in  = err_ff && cnt_ff == LAST_HDR_IDX;
               hdr_in   = hdr_ff >> 8;
               if (cnt_ff == LAST_HDR_IDX) begin
                  cnt_in = 4'd0;
                  state_in = (!err_ff && rec_ff) ? ST_REC : ST_IDLE;
               end else begin
                  cnt_in = cnt_ff + 4'd1;
               end
            end
         end
         default: begin
            if (load_ok) begin
               valid_in = 1'b1;
               data_in  = rec_byte(cnt_ff, answer_ttl, resolved_ip);
               kind_in  = 1'b0;
               last_in  = cnt_ff == 4'd15;
               cnt_in   = cnt_ff + 4'd1;
               if (cnt_ff == 4'd15) begin
                  state_in = ST_IDLE;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= 4'd0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
      end
      rec_ff  <= rec_in;
      err_ff  <= err_in;
      hdr_ff  <= hdr_in;
      data_ff <= data_in;
      last_ff <= last_in;
      kind_ff <= kind_in;
   end

endmodule

[rtl/captive_dns_responder.sv]
// Channel   Direction  Ports                          Contents
// request   in         req_tvalid/tready/tdata/tlast  datagram byte, final-byte mark
// response  out        rsp_tvalid/tready/tdata/tlast  reply byte, final-byte mark,
//                      rsp_tuser                      reply kind (1 = error reply)
// csr       in         csr_we/csr_index/csr_wdata     address, TTL, error RCODE
//
// A passed-through answer byte passes the request queue and the output register
// on its way out, and one byte a cycle flows when the response side keeps up.
// A header reply is copied from the stored header, then sent as 12 bytes;
// the answer record adds 16 bytes after the final byte.
// While a header reply waits in the request queue, bytes of the next datagram
// are held off, since they would overwrite the stored header.
// Reset is synchronous; it empties the queue and restores the register defaults.
module captive_dns_responder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_byte
   output logic        rsp_tlast,
   output logic [0:0]  rsp_tuser,   // [0] reply_kind
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import cdr_pkg::*;

   logic [31:0] ip_ff, ip_in;
   logic [31:0] ttl_ff, ttl_in;
   logic [3:0]  rcode_ff, rcode_in;

   logic        push_valid, fifo_full, fifo_empty, fifo_pop, hdr_taken;
   q_entry_type push_entry, pop_entry;
   hdr_type     header;

   always_comb begin
      ip_in    = ip_ff;
      ttl_in   = ttl_ff;
      rcode_in = rcode_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_RESOLVED_IP: ip_in    = csr_wdata;
            CSR_ANSWER_TTL:  ttl_in   = csr_wdata;
            CSR_ERROR_RCODE: rcode_in = csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ip_ff    <= RESOLVED_IP_RESET;
         ttl_ff   <= ANSWER_TTL_RESET;
         rcode_ff <= ERROR_RCODE_RESET;
      end else begin
         ip_ff    <= ip_in;
         ttl_ff   <= ttl_in;
         rcode_ff <= rcode_in;
      end
   end

   cdr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .fifo_full  (fifo_full),
      .hdr_taken  (hdr_taken),
      .header     (header)
   );

   cdr_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push_valid),
      .push_entry (push_entry),
      .full       (fifo_full),
      .pop        (fifo_pop),
      .pop_entry  (pop_entry),
      .empty      (fifo_empty)
   );

   cdr_back u_back (
      .clock       (clock),
      .reset       (reset),
      .fifo_empty  (fifo_empty),
      .fifo_entry  (pop_entry),
      .fifo_pop    (fifo_pop),
      .header      (header),
      .hdr_taken   (hdr_taken),
      .resolved_ip (ip_ff),
      .answer_ttl  (ttl_ff),
      .error_rcode (rcode_ff),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser)
   );

endmodule

[test/captive_dns_responder_tb.sv]
`timescale 1ns / 1ps

module captive_dns_responder_tb;
   import cdr_pkg::*;

   // Index 3 has no register behind it; a write there must change nothing.
   localparam logic [1:0] CSR_SPARE   = 2'd3;
   localparam logic       KIND_ANSWER = 1'b0;
   localparam logic       KIND_ERROR  = 1'b1;
   localparam int         STALL_LIMIT = 3000;
   localparam int         DRAIN_CYCLES = 60;

   typedef enum logic [1:0] {
      PARSE_HEADER,
      PARSE_PASS,
      PARSE_DISCARD
   } parse_mode_type;

   typedef struct packed {
      logic [7:0] data;
      logic       is_last;
   } dgram_byte_type;

   typedef struct packed {
      logic [7:0] data;
      logic       is_last;
      logic       kind;
   } reply_byte_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'd0;
   logic        req_tlast  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        rsp_tlast;
   logic [0:0]  rsp_tuser;
   logic        csr_we     = 1'b0;
   logic [1:0]  csr_index  = 2'd0;
   logic [31:0] csr_wdata  = 32'd0;

   captive_dns_responder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // Datagram bytes waiting to be offered, and reply bytes still owed by the block.
   dgram_byte_type pending_bytes[$];
   reply_byte_type expected_replies[$];
   logic [7:0]     staging[$];

   // Shadow of the block's parser state and registers.
   logic [7:0]     shadow_hdr [HDR_LEN];
   int             shadow_count = 0;
   parse_mode_type shadow_mode  = PARSE_HEADER;
   logic [31:0]    shadow_ip    = RESOLVED_IP_RESET;
   logic [31:0]    shadow_ttl   = ANSWER_TTL_RESET;
   logic [3:0]     shadow_rcode = ERROR_RCODE_RESET;

   int   mismatches      = 0;
   int   requests_seen   = 0;
   int   replies_checked = 0;
   int   datagrams_sent  = 0;
   int   idle_pct        = 10;
   int   req_gap         = 0;
   int   rsp_gap         = 0;
   int   quiet_cycles    = 0;
   logic req_taken       = 1'b0;

   task automatic push_reply(input logic [7:0] data, input logic is_last, input logic kind);
      reply_byte_type r;
      r.data    = data;
      r.is_last = is_last;
      r.kind    = kind;
      expected_replies.push_back(r);
   endtask

   task automatic push_address_record();
      push_reply(8'hC0, 1'b0, KIND_ANSWER);
      push_reply(8'h0C, 1'b0, KIND_ANSWER);
      push_reply(8'h00, 1'b0, KIND_ANSWER);
      push_reply(8'h01, 1'b0, KIND_ANSWER);
      push_reply(8'h00, 1'b0, KIND_ANSWER);
      push_reply(8'h01, 1'b0, KIND_ANSWER);
      push_reply(shadow_ttl[31:24], 1'b0, KIND_ANSWER);
      push_reply(shadow_ttl[23:16], 1'b0, KIND_ANSWER);
      push_reply(shadow_ttl[15:8], 1'b0, KIND_ANSWER);
      push_reply(shadow_ttl[7:0], 1'b0, KIND_ANSWER);
      push_reply(8'h00, 1'b0, KIND_ANSWER);
      push_reply(8'h04, 1'b0, KIND_ANSWER);
      push_reply(shadow_ip[31:24], 1'b0, KIND_ANSWER);
      push_reply(shadow_ip[23:16], 1'b0, KIND_ANSWER);
      push_reply(shadow_ip[15:8], 1'b0, KIND_ANSWER);
      push_reply(shadow_ip[7:0], 1'b1, KIND_ANSWER);
   endtask

   task automatic predict_reply(input logic [7:0] b, input logic is_last);
      logic [7:0] v;
      case (shadow_mode)
         PARSE_HEADER: begin
            shadow_hdr[shadow_count] = b;
            shadow_count++;
            if (shadow_count < HDR_LEN) begin
               if (is_last) shadow_count = 0;
            end else begin
               shadow_count = 0;
               if (shadow_hdr[2][7]) begin
                  // Responses are dropped silently.
                  shadow_mode = is_last ? PARSE_HEADER : PARSE_DISCARD;
               end else if (shadow_hdr[2][6:3] == 4'd0 &&
                            {shadow_hdr[4], shadow_hdr[5]} == 16'd1 &&
                            {shadow_hdr[6], shadow_hdr[7], shadow_hdr[8], shadow_hdr[9]}
                            == 32'd0) begin
                  for (int i = 0; i < HDR_LEN; i++) begin
                     v = shadow_hdr[i];
                     if (i == 2) v[7] = 1'b1;
                     else if (i == 6) v = shadow_hdr[4];
                     else if (i == 7) v = shadow_hdr[5];
                     push_reply(v, 1'b0, KIND_ANSWER);
                  end
                  if (is_last) begin
                     push_address_record();
                     shadow_mode = PARSE_HEADER;
                  end else begin
                     shadow_mode = PARSE_PASS;
                  end
               end else begin
                  for (int i = 0; i < HDR_LEN; i++) begin
                     v = shadow_hdr[i];
                     if (i == 2) v[7] = 1'b1;
                     else if (i == 3) v = {v[7:4], shadow_rcode};
                     else if (i == 4 || i == 5) v = 8'd0;
                     push_reply(v, i == HDR_LEN - 1, KIND_ERROR);
                  end
                  shadow_mode = is_last ? PARSE_HEADER : PARSE_DISCARD;
               end
            end
         end
         PARSE_PASS: begin
            push_reply(b, 1'b0, KIND_ANSWER);
            if (is_last) begin
               push_address_record();
               shadow_mode  = PARSE_HEADER;
               shadow_count = 0;
            end
         end
         default: begin
            if (is_last) begin
               shadow_mode  = PARSE_HEADER;
               shadow_count = 0;
            end
         end
      endcase
   endtask

   // Request side and response back-pressure, both changed on the falling edge.
   always @(negedge clock) begin : driver
      dgram_byte_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
         rsp_tready <= 1'b0;
      end else begin
         if (!req_tvalid || req_taken) begin
            if (req_gap > 0) begin
               req_gap--;
               req_tvalid <= 1'b0;
            end else if ($urandom_range(99, 0) < idle_pct) begin
               req_gap = $urandom_range(13, 0);
               req_tvalid <= 1'b0;
            end else if (pending_bytes.size() > 0) begin
               nxt = pending_bytes.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= nxt.data;
               req_tlast  <= nxt.is_last;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_tready <= 1'b0;
         end else if ($urandom_range(99, 0) < idle_pct) begin
            rsp_gap = $urandom_range(13, 0);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : monitor
      reply_byte_type got;
      reply_byte_type want;
      req_taken = 1'b0;
      if (!reset) begin
         if (csr_we) begin
            case (csr_index)
               CSR_RESOLVED_IP: shadow_ip    = csr_wdata;
               CSR_ANSWER_TTL:  shadow_ttl   = csr_wdata;
               CSR_ERROR_RCODE: shadow_rcode = csr_wdata[3:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            predict_reply(req_tdata, req_tlast);
            req_taken = 1'b1;
            requests_seen++;
         end
         if (rsp_tvalid && rsp_tready) begin
            got.data    = rsp_tdata;
            got.is_last = rsp_tlast;
            got.kind    = rsp_tuser[0];
            replies_checked++;
            if (expected_replies.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: reply byte %02h last=%0b kind=%0b with none expected",
                           $realtime, got.data, got.is_last, got.kind);
            end else begin
               want = expected_replies.pop_front();
               if (got.data !== want.data || got.is_last !== want.is_last ||
                   got.kind !== want.kind) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("%0t: reply byte %02h last=%0b kind=%0b, expected %02h %0b %0b",
                              $realtime, got.data, got.is_last, got.kind,
                              want.data, want.is_last, want.kind);
               end
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("Watchdog: no transfer for %0d cycles", STALL_LIMIT);
            $display("FAILURE");
            $finish;
         end
      end
   end

   task automatic send_datagram();
      dgram_byte_type d;
      for (int i = 0; i < staging.size(); i++) begin
         d.data    = staging[i];
         d.is_last = (i == staging.size() - 1);
         pending_bytes.push_back(d);
      end
      staging.delete();
      datagrams_sent++;
   endtask

   task automatic build_header(input logic qr, input logic [3:0] opcode,
                               input logic [15:0] qd, input logic [15:0] an,
                               input logic [15:0] ns);
      logic [2:0] flag_bits;
      flag_bits = 3'($urandom);
      staging.push_back(8'($urandom));
      staging.push_back(8'($urandom));
      staging.push_back({qr, opcode, flag_bits});
      staging.push_back(8'($urandom));
      staging.push_back(qd[15:8]);
      staging.push_back(qd[7:0]);
      staging.push_back(an[15:8]);
      staging.push_back(an[7:0]);
      staging.push_back(ns[15:8]);
      staging.push_back(ns[7:0]);
      staging.push_back(8'($urandom));
      staging.push_back(8'($urandom));
   endtask

   task automatic add_tail(input int n);
      for (int i = 0; i < n; i++) staging.push_back(8'($urandom));
   endtask

   task automatic random_traffic(input int budget);
      int          start_len;
      int          pick;
      logic [3:0]  opcode;
      logic [15:0] qd;
      logic [15:0] an;
      logic [15:0] ns;
      start_len = pending_bytes.size();
      while (pending_bytes.size() - start_len < budget) begin
         pick = $urandom_range(99, 0);
         if (pick < 60) begin
            build_header(1'b0, 4'd0, 16'd1, 16'd0, 16'd0);
            add_tail(($urandom_range(3, 0) == 0) ? 0 : $urandom_range(24, 1));
         end else if (pick < 75) begin
            opcode = 4'd0;
            qd = 16'd1;
            an = 16'd0;
            ns = 16'd0;
            case ($urandom_range(3, 0))
               0: opcode = 4'($urandom_range(15, 1));
               1: begin
                  qd = 16'($urandom);
                  if (qd == 16'd1) qd = 16'd2;
               end
               2: an = 16'($urandom_range(65535, 1));
               default: ns = 16'($urandom_range(65535, 1));
            endcase
            build_header(1'b0, opcode, qd, an, ns);
            add_tail($urandom_range(8, 0));
         end else if (pick < 83) begin
            build_header(1'b1, 4'($urandom), 16'($urandom), 16'($urandom),
                         16'($urandom));
            add_tail($urandom_range(8, 0));
         end else if (pick < 91) begin
            add_tail($urandom_range(11, 1));
         end else begin
            add_tail($urandom_range(30, 1));
         end
         send_datagram();
      end
   endtask

   // Waits until the block has drained, so that a register write cannot land mid-datagram.
   task automatic settle();
      while (pending_bytes.size() != 0 || req_tvalid) @(posedge clock);
      while (expected_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] index, input logic [31:0] value);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = index;
      csr_wdata = value;
      @(negedge clock);
      csr_we    = 1'b0;
   endtask

   initial begin : stimulus
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part under the reset register values.
      build_header(1'b0, 4'd0, 16'd1, 16'd0, 16'd0);      // header ends the datagram
      send_datagram();
      build_header(1'b0, 4'd0, 16'd1, 16'd0, 16'd0);
      staging.push_back(8'h00);
      staging.push_back(8'hFF);
      add_tail(3);
      send_datagram();
      build_header(1'b0, 4'hF, 16'd1, 16'd0, 16'd0);      // non-zero opcode
      add_tail(3);
      send_datagram();
      build_header(1'b0, 4'd0, 16'd0, 16'd0, 16'd0);      // no question at all
      send_datagram();
      build_header(1'b0, 4'd0, 16'hFFFF, 16'd0, 16'd0);
      add_tail(1);
      send_datagram();
      build_header(1'b0, 4'd0, 16'd1, 16'hFFFF, 16'd0);
      send_datagram();
      build_header(1'b0, 4'd0, 16'd1, 16'd0, 16'h0100);
      send_datagram();
      build_header(1'b1, 4'd0, 16'd1, 16'd0, 16'd0);      // a response, dropped
      add_tail(4);
      send_datagram();
      staging.push_back(8'hFF);                           // far too short
      send_datagram();
      add_tail(11);                                       // one byte short of a header
      send_datagram();
      settle();

      write_csr(CSR_RESOLVED_IP, 32'hFFFF_FFFF);
      write_csr(CSR_ANSWER_TTL, 32'd0);
      write_csr(CSR_ERROR_RCODE, 32'd0);
      write_csr(CSR_SPARE, $urandom);
      random_traffic(55);
      settle();

      write_csr(CSR_RESOLVED_IP, 32'd0);
      write_csr(CSR_ANSWER_TTL, 32'hFFFF_FFFF);
      write_csr(CSR_ERROR_RCODE, {28'($urandom_range(32'h0FFF_FFFF, 0)), 4'hF});
      idle_pct = 25;
      random_traffic(55);
      settle();

      write_csr(CSR_RESOLVED_IP, $urandom);
      write_csr(CSR_ANSWER_TTL, $urandom);
      write_csr(CSR_ERROR_RCODE, $urandom);
      idle_pct = 5;
      random_traffic(55);
      settle();

      // Closing stretch at full rate on both sides.
      write_csr(CSR_RESOLVED_IP, $urandom);
      write_csr(CSR_ANSWER_TTL, $urandom);
      write_csr(CSR_ERROR_RCODE, $urandom);
      idle_pct = 0;
      random_traffic(55);
      settle();

      $display("Sent %0d datagrams (%0d bytes accepted) across five register settings.",
               datagrams_sent, requests_seen);
      $display("Checked %0d reply bytes; %0d mismatches, %0d replies outstanding.",
               replies_checked, mismatches, expected_replies.size());
      if (mismatches == 0 && expected_replies.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
